/* sv/lwt_pkg.sv */
// Shared constants, codes and byte-class functions of the Latin-1 word tokeniser.
// No dependencies; compiled first.
package lwt_pkg;

   localparam int OFFSET_BITS_DEF = 24;
   localparam int MAX_WORD        = 128;
   localparam int NUM_W           = 24;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 8;
   localparam int MIN_KEEP_LEN    = 2;
   localparam logic [7:0] WORD_LIMIT_RST = 8'd64;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_DROP   = 2'd2;
   localparam logic [1:0] KIND_DOCEND = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_SINGLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_NUMBERS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_LIMIT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLD_CASE    = 2'd3;

   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_MICRO  = 8'hB5;
   localparam logic [7:0] CHAR_TIMES  = 8'hD7;
   localparam logic [7:0] CHAR_DIVIDE = 8'hF7;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CASE_STEP   = 8'h20;

   function automatic logic is_ascii_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_ascii_letter(c) || (c >= "0" && c <= "9") ||
             c == CHAR_HYPHEN || c == CHAR_SLASH || c == CHAR_MICRO ||
             (c >= 8'hC0 && c <= 8'hFE && c != CHAR_TIMES && c != CHAR_DIVIDE);
   endfunction

   function automatic logic is_space_char(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      logic upper;
      upper = (c >= "A" && c <= "Z") || (c >= 8'hC0 && c <= 8'hDE && c != CHAR_TIMES);
      return (en && upper) ? c + CASE_STEP : c;
   endfunction

endpackage

/* sv/lwt_req_if.sv */
// Input channel of the tokeniser: one document byte per transaction.
// Depends on lwt_pkg.
interface lwt_req_if;
   import lwt_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       doc_end;

   modport source (output valid, output text_byte, output doc_end, input ready);
   modport sink   (input valid, input text_byte, input doc_end, output ready);
endinterface

/* sv/lwt_rsp_if.sv */
// Result channel of the tokeniser: one word byte, verdict or document end per transaction.
// Depends on lwt_pkg.
interface lwt_rsp_if #(
   parameter int OFFSET_BITS = lwt_pkg::OFFSET_BITS_DEF
);
   import lwt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [7:0]             word_byte;
   logic [NUM_W-1:0]       word_number;
   logic [OFFSET_BITS-1:0] start_pos;
   logic [OFFSET_BITS-1:0] end_pos;
   logic [7:0]             word_len;
   logic                   last;

   modport source (output valid, output kind, output word_byte, output word_number,
                   output start_pos, output end_pos, output word_len, output last,
                   input ready);
   modport sink   (input valid, input kind, input word_byte, input word_number,
                   input start_pos, input end_pos, input word_len, input last,
                   output ready);
endinterface

/* sv/latin1_word_tokenizer_top.sv */
// Latin-1 word tokeniser: top level with input register, classifier and result queue.
// Depends on lwt_pkg, lwt_req_if and lwt_rsp_if.
//
// Usage:
//   req_ch carries one document byte per transaction, doc_end marking the last byte.
//   rsp_ch carries the results of each byte in order: word byte, verdict, document
//   end; last is set on the final result of a byte. A byte may give no result.
//   csr_* writes allow_single, keep_numbers, word_limit and fold_case; write only
//   while no byte is in flight.
// Path: a byte accepted is registered in the input register, classified from it, and
//   its results are loaded into the result queue and presented from there.
// Throughput: one byte per cycle while rsp_ch.ready is high and each byte gives at
//   most one result. A byte with more results holds the three-slot result queue
//   until its last is taken; the result port delivers one transaction per cycle.
// Reset: synchronous; clears word state, offsets, word numbering, the queue and
//   loads the register defaults. No sweep follows.
// Stall: while rsp_ch.ready is low the queue holds; one further byte waits in
//   the input register, then req_ch.ready drops.
module latin1_word_tokenizer_top #(
   parameter int OFFSET_BITS = lwt_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   lwt_req_if.sink                             req_ch,
   lwt_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [lwt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lwt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lwt_pkg::*;

   typedef struct packed {
      logic [1:0]             kind;
      logic [7:0]             word_byte;
      logic [NUM_W-1:0]       word_number;
      logic [OFFSET_BITS-1:0] start_pos;
      logic [OFFSET_BITS-1:0] end_pos;
      logic [7:0]             word_len;
   } result_type;

   // configuration
   logic       allow_single_ff, keep_numbers_ff, fold_case_ff;
   logic [7:0] word_limit_ff;
   logic [7:0] lim;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // word state
   logic [7:0]             char_count_ff, char_count_in;
   logic                   skipping_ff, skipping_in;
   logic                   seen_letter_ff, seen_letter_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] word_start_ff, word_start_in;
   logic [NUM_W-1:0]       accepted_ff, accepted_in;

   // result queue
   result_type slot_ff [3];
   result_type res     [3];
   logic [1:0] cnt_ff, res_cnt;

   logic load, pop, req_fire;

   function automatic result_type make_verdict(
      input logic [7:0]             cc,
      input logic                   seen,
      input logic [OFFSET_BITS-1:0] ws,
      input logic [NUM_W-1:0]       acc,
      input logic [OFFSET_BITS-1:0] endp,
      input logic [7:0]             limit,
      input logic                   allow,
      input logic                   keep
   );
      result_type r;
      logic [7:0] len;
      logic       drop;
      len  = (cc < limit) ? cc : limit;
      drop = (len < 8'(MIN_KEEP_LEN) && !allow) || (!seen && !keep);
      r             = '0;
      r.kind        = drop ? KIND_DROP : KIND_ACCEPT;
      r.word_number = drop ? '0 : acc;
      r.start_pos   = ws;
      r.end_pos     = endp;
      r.word_len    = len;
      return r;
   endfunction

   always_comb begin
      if (word_limit_ff == 8'd0) begin
         lim = 8'd1;
      end else if (word_limit_ff > 8'(MAX_WORD)) begin
         lim = 8'(MAX_WORD);
      end else begin
         lim = word_limit_ff;
      end
   end

   always_comb begin
      logic       consumed;
      logic [7:0] c;
      char_count_in  = char_count_ff;
      skipping_in    = skipping_ff;
      seen_letter_in = seen_letter_ff;
      word_start_in  = word_start_ff;
      accepted_in    = accepted_ff;
      res_cnt        = 2'd0;
      consumed       = 1'b0;
      c              = fold_byte(in_byte_ff, fold_case_ff);
      for (int i = 0; i < 3; i++) begin
         res[i] = '0;
      end

      if (skipping_ff) begin
         if (is_space_char(in_byte_ff)) begin
            consumed = 1'b1;
         end else begin
            skipping_in = 1'b0;
         end
      end
      if (!consumed && char_count_ff != 8'd0 && in_byte_ff == CHAR_HYPHEN) begin
         skipping_in = 1'b1;
         consumed    = 1'b1;
      end
      if (!consumed) begin
         if (is_word_char(c)) begin
            if (char_count_ff == 8'd0) begin
               word_start_in = offset_ff;
            end
            if (char_count_ff < lim) begin
               res[res_cnt].kind      = KIND_BYTE;
               res[res_cnt].word_byte = c;
               res_cnt                = res_cnt + 2'd1;
               if (is_ascii_letter(c)) begin
                  seen_letter_in = 1'b1;
               end
            end
            if (char_count_ff != 8'hFF) begin
               char_count_in = char_count_ff + 8'd1;
            end
         end else if (char_count_ff != 8'd0) begin
            res[res_cnt] = make_verdict(char_count_ff, seen_letter_ff, word_start_ff,
                                        accepted_ff, offset_ff, lim,
                                        allow_single_ff, keep_numbers_ff);
            if (res[res_cnt].kind == KIND_ACCEPT) begin
               accepted_in = accepted_ff + NUM_W'(1);
            end
            res_cnt        = res_cnt + 2'd1;
            char_count_in  = 8'd0;
            seen_letter_in = 1'b0;
            skipping_in    = 1'b0;
         end
      end

      offset_in = offset_ff + OFFSET_BITS'(1);

      if (in_end_ff) begin
         if (char_count_in != 8'd0) begin
            res[res_cnt] = make_verdict(char_count_in, seen_letter_in, word_start_in,
                                        accepted_in, offset_in, lim,
                                        allow_single_ff, keep_numbers_ff);
            if (res[res_cnt].kind == KIND_ACCEPT) begin
               accepted_in = accepted_in + NUM_W'(1);
            end
            res_cnt = res_cnt + 2'd1;
         end
         res[res_cnt].kind        = KIND_DOCEND;
         res[res_cnt].word_number = accepted_in;
         res[res_cnt].end_pos     = offset_in;
         res_cnt                  = res_cnt + 2'd1;
         char_count_in  = 8'd0;
         skipping_in    = 1'b0;
         seen_letter_in = 1'b0;
         offset_in      = '0;
         word_start_in  = '0;
         accepted_in    = '0;
      end
   end

   assign pop      = (cnt_ff != 2'd0) && rsp_ch.ready;
   assign load     = in_valid_ff && ((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ch.ready));
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || load;

   assign rsp_ch.valid       = cnt_ff != 2'd0;
   assign rsp_ch.kind        = slot_ff[0].kind;
   assign rsp_ch.word_byte   = slot_ff[0].word_byte;
   assign rsp_ch.word_number = slot_ff[0].word_number;
   assign rsp_ch.start_pos   = slot_ff[0].start_pos;
   assign rsp_ch.end_pos     = slot_ff[0].end_pos;
   assign rsp_ch.word_len    = slot_ff[0].word_len;
   assign rsp_ch.last        = cnt_ff == 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_single_ff <= 1'b0;
         keep_numbers_ff <= 1'b0;
         word_limit_ff   <= WORD_LIMIT_RST;
         fold_case_ff    <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALLOW_SINGLE: allow_single_ff <= csr_wdata[0];
            CSR_KEEP_NUMBERS: keep_numbers_ff <= csr_wdata[0];
            CSR_WORD_LIMIT:   word_limit_ff   <= csr_wdata;
            CSR_FOLD_CASE:    fold_case_ff    <= csr_wdata[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.text_byte;
         in_end_ff  <= req_ch.doc_end;
      end
      if (load) begin
         slot_ff <= res;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         cnt_ff         <= 2'd0;
         char_count_ff  <= 8'd0;
         skipping_ff    <= 1'b0;
         seen_letter_ff <= 1'b0;
         offset_ff      <= '0;
         word_start_ff  <= '0;
         accepted_ff    <= '0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end
         if (load) begin
            cnt_ff         <= res_cnt;
            char_count_ff  <= char_count_in;
            skipping_ff    <= skipping_in;
            seen_letter_ff <= seen_letter_in;
            offset_ff      <= offset_in;
            word_start_ff  <= word_start_in;
            accepted_ff    <= accepted_in;
         end else if (pop) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of latin1_word_tokenizer_top: directed and random byte streams,
// results compared field by field with a built-in tokeniser prediction.
// Depends on lwt_pkg, lwt_req_if, lwt_rsp_if and the top level of the block.
module testbench;
   import lwt_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int OFF_W        = OFFSET_BITS_DEF;
   localparam int QUIET_LIMIT  = 400;
   localparam int SETTLE_TICKS = 8;
   localparam int DRAIN_TICKS  = 8;
   localparam int PHASE_ITEMS  = 12;

   typedef struct {
      logic [1:0]       kind;
      logic [7:0]       word_byte;
      logic [NUM_W-1:0] word_number;
      logic [OFF_W-1:0] start_pos;
      logic [OFF_W-1:0] end_pos;
      logic [7:0]       word_len;
      logic             last;
   } token_type;

   typedef struct {
      logic [7:0] text;
      logic       fin;
      logic       typed;
      token_type  want;
   } stim_row_type;

   typedef struct {
      logic       single;
      logic       numbers;
      logic [7:0] limit;
      logic       fold;
      bit         long_word;
   } phase_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic rsp_take = 1'b1;
   int   hold_left = 0;
   bit   calm = 1'b0;
   int   quiet_cycles = 0;
   int   mismatches = 0;

   // tokeniser prediction: settings and word state
   logic             cfg_single;
   logic             cfg_numbers;
   logic [7:0]       cfg_limit;
   logic             cfg_fold;
   logic [7:0]       run_len;
   logic             after_hyphen;
   logic [OFF_W-1:0] next_offset;
   logic [OFF_W-1:0] word_head;
   logic [NUM_W-1:0] kept_words;
   logic             has_letter;

   token_type expected_tokens[$];

   lwt_req_if req_ch ();
   lwt_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_take;

   latin1_word_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic is_alpha_ascii(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_token_byte(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CHAR_HYPHEN, CHAR_SLASH,
                       CHAR_MICRO, [8'hC0:8'hD6], [8'hD8:8'hF6], [8'hF8:8'hFE]};
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CHAR_SPACE, [8'h09:8'h0D]};
   endfunction

   function automatic logic [7:0] lower_latin1(input logic [7:0] c);
      if (cfg_fold && (c inside {[8'h41:8'h5A], [8'hC0:8'hD6], [8'hD8:8'hDE]}))
         return c + CASE_STEP;
      return c;
   endfunction

   function automatic logic [7:0] stored_cap();
      if (cfg_limit == 8'd0)
         return 8'd1;
      if (cfg_limit > 8'(MAX_WORD))
         return 8'(MAX_WORD);
      return cfg_limit;
   endfunction

   function automatic void push_token(input logic [1:0] kind, input logic [7:0] b,
                                      input logic [NUM_W-1:0] num, input logic [OFF_W-1:0] st,
                                      input logic [OFF_W-1:0] en, input logic [7:0] len);
      token_type t;
      t = '{kind, b, num, st, en, len, 1'b0};
      expected_tokens.push_back(t);
   endfunction

   function automatic void close_word(input logic [OFF_W-1:0] end_at);
      logic [7:0] cap;
      logic [7:0] len;
      cap = stored_cap();
      len = (run_len < cap) ? run_len : cap;
      if ((len < 8'(MIN_KEEP_LEN) && !cfg_single) || (!has_letter && !cfg_numbers)) begin
         push_token(KIND_DROP, 8'd0, '0, word_head, end_at, len);
      end else begin
         push_token(KIND_ACCEPT, 8'd0, kept_words, word_head, end_at, len);
         kept_words = kept_words + NUM_W'(1);
      end
      run_len = 8'd0;
      has_letter = 1'b0;
      after_hyphen = 1'b0;
   endfunction

   function automatic void clear_word_state();
      run_len = 8'd0;
      after_hyphen = 1'b0;
      has_letter = 1'b0;
      next_offset = '0;
      word_head = '0;
      kept_words = '0;
   endfunction

   function automatic void tokenise_byte(input logic [7:0] raw, input logic fin);
      int         first;
      bit         taken;
      logic [7:0] c;
      first = expected_tokens.size();
      taken = 1'b0;
      if (after_hyphen) begin
         if (is_blank(raw) && !is_token_byte(raw))
            taken = 1'b1;
         else
            after_hyphen = 1'b0;
      end
      if (!taken && run_len != 8'd0 && raw == CHAR_HYPHEN) begin
         after_hyphen = 1'b1;
         taken = 1'b1;
      end
      if (!taken) begin
         c = lower_latin1(raw);
         if (is_token_byte(c)) begin
            if (run_len == 8'd0)
               word_head = next_offset;
            if (run_len < stored_cap()) begin
               push_token(KIND_BYTE, c, '0, '0, '0, 8'd0);
               if (is_alpha_ascii(c))
                  has_letter = 1'b1;
            end
            if (run_len != 8'hFF)
               run_len = run_len + 8'd1;
         end else if (run_len != 8'd0) begin
            close_word(next_offset);
         end
      end
      next_offset = next_offset + OFF_W'(1);
      if (fin) begin
         if (run_len != 8'd0)
            close_word(next_offset);
         push_token(KIND_DOCEND, 8'd0, kept_words, '0, next_offset, 8'd0);
         clear_word_state();
      end
      if (expected_tokens.size() > first)
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_token();
      token_type want;
      if (expected_tokens.size() == 0) begin
         $error("kind: expected nothing, got %0d (byte %02h)", rsp_ch.kind, rsp_ch.word_byte);
         mismatches++;
         return;
      end
      want = expected_tokens.pop_front();
      compare("kind", 32'(want.kind), 32'(rsp_ch.kind));
      compare("word_byte", 32'(want.word_byte), 32'(rsp_ch.word_byte));
      compare("word_number", 32'(want.word_number), 32'(rsp_ch.word_number));
      compare("start_pos", 32'(want.start_pos), 32'(rsp_ch.start_pos));
      compare("end_pos", 32'(want.end_pos), 32'(rsp_ch.end_pos));
      compare("word_len", 32'(want.word_len), 32'(rsp_ch.word_len));
      compare("last", 32'(want.last), 32'(rsp_ch.last));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready)
            check_token();
      end
   end

   // hold the result channel in short bursts
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_take <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         hold_left <= $urandom_range(0, 4);
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= 1'b1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic stim_row_type plain(input logic [7:0] b, input logic fin);
      stim_row_type r;
      r.text = b;
      r.fin = fin;
      r.typed = 1'b0;
      r.want = '{KIND_BYTE, 8'd0, '0, '0, '0, 8'd0, 1'b0};
      return r;
   endfunction

   function automatic stim_row_type known(input logic [7:0] b, input logic fin,
                                          input token_type t);
      stim_row_type r;
      r.text = b;
      r.fin = fin;
      r.typed = 1'b1;
      r.want = t;
      return r;
   endfunction

   function automatic logic [7:0] pick_word_byte();
      case ($urandom_range(0, 9))
         0, 1:    return 8'h41 + 8'($urandom_range(0, 25));
         2, 3, 4: return 8'h61 + 8'($urandom_range(0, 25));
         5:       return 8'h30 + 8'($urandom_range(0, 9));
         6:       return 8'($urandom_range(8'hC0, 8'hFE));
         7:       return CHAR_HYPHEN;
         default: return $urandom_range(0, 1) ? CHAR_SLASH : CHAR_MICRO;
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CHAR_SPACE;
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 9))
         0:       return 8'h2C;
         1:       return 8'h2E;
         2:       return CHAR_TIMES;
         3:       return CHAR_DIVIDE;
         4:       return 8'h00;
         default: return pick_blank();
      endcase
   endfunction

   task automatic feed_row(input stim_row_type row);
      int depth;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= row.text;
      req_ch.doc_end <= row.fin;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      depth = expected_tokens.size();
      tokenise_byte(row.text, row.fin);
      if (row.typed) begin
         while (expected_tokens.size() > depth)
            void'(expected_tokens.pop_back());
         expected_tokens.push_back(row.want);
      end
      @(negedge clock);
   endtask

   task automatic feed(input logic [7:0] b, input logic fin);
      feed_row(plain(b, fin));
   endtask

   task automatic feed_text(input int items, input bit long_word);
      int         sent;
      int         n;
      logic [7:0] b;
      sent = 0;
      if (long_word) begin
         repeat (int'(stored_cap()) + 2) feed(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
         feed(CHAR_SPACE, 1'b0);
      end
      while (sent < items) begin
         if ($urandom_range(0, 6) == 0) begin
            feed(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            sent++;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            repeat (n) begin
               b = pick_word_byte();
               feed(b, 1'b0);
               sent++;
               if (b == CHAR_HYPHEN && $urandom_range(0, 1) == 1) begin
                  repeat ($urandom_range(1, 2)) begin
                     feed(pick_blank(), 1'b0);
                     sent++;
                  end
               end
            end
            feed(pick_separator(), $urandom_range(0, 9) == 0);
            sent++;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   task automatic apply_settings(input phase_type p);
      write_csr(CSR_ALLOW_SINGLE, CSR_DATA_W'(p.single));
      write_csr(CSR_KEEP_NUMBERS, CSR_DATA_W'(p.numbers));
      write_csr(CSR_WORD_LIMIT, p.limit);
      write_csr(CSR_FOLD_CASE, CSR_DATA_W'(p.fold));
      csr_wr_en <= 1'b0;
      cfg_single = p.single;
      cfg_numbers = p.numbers;
      cfg_limit = p.limit;
      cfg_fold = p.fold;
   endtask

   task automatic settle();
      while (expected_tokens.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   initial begin
      stim_row_type directed[$];
      phase_type    plan[6];

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.text_byte = 8'd0;
      req_ch.doc_end = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_single = 1'b0;
      cfg_numbers = 1'b0;
      cfg_limit = WORD_LIMIT_RST;
      cfg_fold = 1'b1;
      clear_word_state();

      directed.push_back(known(8'h51, 1'b0, '{KIND_BYTE, 8'h71, '0, '0, '0, 8'd0, 1'b1}));
      directed.push_back(known(8'hDE, 1'b0, '{KIND_BYTE, 8'hFE, '0, '0, '0, 8'd0, 1'b1}));
      directed.push_back(known(CHAR_SPACE, 1'b0,
                               '{KIND_ACCEPT, 8'd0, '0, '0, OFF_W'(2), 8'd2, 1'b1}));
      directed.push_back(plain(8'h00, 1'b0));
      directed.push_back(plain(8'h78, 1'b0));
      directed.push_back(plain(8'h0D, 1'b0));
      directed.push_back(plain(CHAR_HYPHEN, 1'b0));
      directed.push_back(plain(8'h35, 1'b0));
      directed.push_back(plain(8'hFF, 1'b0));
      directed.push_back(plain(8'h61, 1'b0));
      directed.push_back(plain(CHAR_HYPHEN, 1'b0));
      directed.push_back(plain(8'h09, 1'b0));
      directed.push_back(plain(8'h0A, 1'b0));
      directed.push_back(plain(8'h62, 1'b0));
      directed.push_back(plain(CHAR_MICRO, 1'b0));
      directed.push_back(plain(CHAR_SLASH, 1'b0));
      directed.push_back(plain(8'hC0, 1'b0));
      directed.push_back(plain(CHAR_TIMES, 1'b0));
      directed.push_back(plain(CHAR_DIVIDE, 1'b0));
      directed.push_back(plain(8'h5A, 1'b0));
      directed.push_back(plain(8'h6D, 1'b1));
      directed.push_back(known(CHAR_SPACE, 1'b1,
                               '{KIND_DOCEND, 8'd0, '0, '0, OFF_W'(1), 8'd0, 1'b1}));
      directed.push_back(plain(CHAR_HYPHEN, 1'b0));
      directed.push_back(plain(8'hFE, 1'b0));
      directed.push_back(plain(CHAR_SPACE, 1'b1));

      plan[0] = '{1'b1, 1'b1, 8'd1, 1'b0, 1'b0};
      plan[1] = '{1'b0, 1'b1, 8'd40, 1'b1, 1'b1};
      plan[2] = '{1'b1, 1'b0, 8'd0, 1'b1, 1'b0};
      plan[3] = '{1'b1, 1'b1, 8'd255, 1'b0, 1'b0};
      plan[4] = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0};
      plan[5] = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(1, 8)), 1'($urandom_range(0, 1)), 1'b0};

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i])
         feed_row(directed[i]);

      foreach (plan[p]) begin
         req_ch.valid <= 1'b0;
         settle();
         apply_settings(plan[p]);
         // drop idling for the closing stretch
         if (p == 5)
            calm = 1'b1;
         feed_text(PHASE_ITEMS, plan[p].long_word);
      end
      req_ch.valid <= 1'b0;

      while (expected_tokens.size() != 0)
         @(negedge clock);
      repeat (DRAIN_TICKS) @(negedge clock);

      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
sv/lwt_pkg.sv
sv/lwt_req_if.sv
sv/lwt_rsp_if.sv
sv/latin1_word_tokenizer_top.sv
dv/testbench.sv
